>>> design/frs_pkg.sv
// Shared constants, codes and control structures of the framed receiver.
`default_nettype none
package frs_pkg;
    localparam int PendingEntries = 16;
    localparam int FrameBytes = 256;
    localparam int MaxResults = 16;
    localparam int ByteWidth = 8;
    localparam int AddrWidth = $clog2(FrameBytes);

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_ARM = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    typedef struct packed {
        logic accept;
        logic scan_rm;
        logic scan_tick;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic table_full;
        logic scan_end;
        logic hold_valid;
        logic out_free;
    } dp_status_t;
endpackage
`default_nettype wire

>>> design/frs_ctrl.sv
// Controller state machine that sequences transactions through the datapath.
`default_nettype none
module frs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         cmd,
    input  wire frs_pkg::dp_status_t st,
    output frs_pkg::ctrl_cmd_t      ctl
);
    import frs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RMSCAN = 4'b0010,
        S_TSCAN  = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        ctl.accept = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_BYTE: if (st.frame_done) state_next = S_RMSCAN;
                        CMD_TICK: state_next = S_TSCAN;
                        CMD_ARM: if (st.table_full) state_next = S_EMIT;
                        CMD_READ: state_next = S_EMIT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RMSCAN:
            begin
                ctl.scan_rm = 1'b1;
                if (st.scan_end) state_next = S_EMIT;
            end
            S_TSCAN:
            begin
                ctl.scan_tick = 1'b1;
                if (st.scan_end) state_next = st.hold_valid ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                ctl.emit = 1'b1;
                if (st.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

>>> design/frs_dp.sv
// Datapath with the frame store, the pending reply table and the result register.
`default_nettype none
module frs_dp #(
    parameter int PENDING_ENTRIES = frs_pkg::PendingEntries
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire frs_pkg::ctrl_cmd_t ctl,
    output frs_pkg::dp_status_t     st,
    input  wire logic [1:0]         cmd,
    input  wire logic [7:0]         rx_byte,
    input  wire logic [7:0]         req_id,
    input  wire logic [31:0]        wait_ms,
    input  wire logic [7:0]         read_pos,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic [1:0]              kind,
    output logic [7:0]              frame_id,
    output logic [7:0]              payload_len,
    output logic [7:0]              read_data,
    output logic                    last
);
    import frs_pkg::*;

    localparam int N = PENDING_ENTRIES;
    localparam int CW = $clog2(N + 1);
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int NRW = $clog2(MaxResults + 1);

    logic [7:0] mem [FrameBytes];
    logic [FrameBytes-1:0] vbits_reg;
    logic [7:0] rdata_reg;
    logic rvld_reg;
    logic rpos1_reg;

    logic [7:0] bc_reg;
    logic [7:0] len_reg;
    logic [7:0] fid_reg;
    logic [31:0] now_reg;

    logic [7:0] ids_reg [N];
    logic [31:0] start_reg [N];
    logic [31:0] limit_reg [N];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [NRW-1:0] nres_reg;
    logic hold_v_reg;
    logic [7:0] hold_id_reg;

    logic [1:0] res_kind_reg;
    logic [7:0] res_id_reg;
    logic [7:0] res_plen_reg;

    logic out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] id_reg;
    logic [7:0] plen_reg;
    logic [7:0] data_reg;
    logic last_reg;

    logic is_byte, is_tick, is_arm, is_read;
    logic stored, done;
    logic [7:0] new_bc, new_len, new_fid;
    logic full, out_free, scan_end;
    logic [CW-1:0] e_full;
    logic [IW-1:0] eidx;
    logic expired, hit_rm, tick_go, tick_hit, shift_en, idx_dec, push, emit_load;

    always_comb
    begin
        is_byte = ctl.accept && (cmd == CMD_BYTE);
        is_tick = ctl.accept && (cmd == CMD_TICK);
        is_arm = ctl.accept && (cmd == CMD_ARM);
        is_read = ctl.accept && (cmd == CMD_READ);
        stored = (bc_reg != 8'd0) || (rx_byte == 8'd0);
        new_bc = bc_reg + 8'd1;
        new_len = (bc_reg == 8'd1) ? rx_byte : len_reg;
        new_fid = (bc_reg == 8'd2) ? rx_byte : fid_reg;
        done = stored && (new_len > 8'd2) && (new_len == new_bc);
        full = (cnt_reg == CW'(N));
        out_free = !out_valid_reg || !out_stall;
        scan_end = (idx_reg == '0) || (ctl.scan_tick && nres_reg == NRW'(MaxResults));
        e_full = idx_reg - CW'(1);
        eidx = e_full[IW-1:0];
        expired = (now_reg - start_reg[eidx]) > limit_reg[eidx];
        hit_rm = ctl.scan_rm && !scan_end && (ids_reg[eidx] == res_id_reg);
        tick_go = ctl.scan_tick && !scan_end && (!expired || !hold_v_reg || out_free);
        tick_hit = tick_go && expired;
        shift_en = hit_rm || tick_hit;
        idx_dec = (ctl.scan_rm && !scan_end) || tick_go;
        push = tick_hit && hold_v_reg;
        emit_load = ctl.emit && out_free;
        st.frame_done = (cmd == CMD_BYTE) && done;
        st.table_full = full;
        st.scan_end = scan_end;
        st.hold_valid = hold_v_reg;
        st.out_free = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (is_byte && stored) mem[bc_reg] <= rx_byte;
        if (is_read)
        begin
            rdata_reg <= mem[read_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg <= '0;
            rvld_reg <= 1'b0;
            rpos1_reg <= 1'b0;
            bc_reg <= '0;
            len_reg <= '0;
            fid_reg <= '0;
            now_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
            nres_reg <= '0;
            hold_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_read)
            begin
                rvld_reg <= vbits_reg[read_pos];
                rpos1_reg <= (read_pos == 8'd1);
            end
            if (is_byte && stored)
            begin
                vbits_reg[bc_reg] <= 1'b1;
                if (bc_reg == 8'd2) fid_reg <= rx_byte;
                if (done)
                begin
                    bc_reg <= '0;
                    len_reg <= '0;
                end
                else
                begin
                    bc_reg <= new_bc;
                    if (bc_reg == 8'd1) len_reg <= rx_byte;
                end
            end
            if (is_tick) now_reg <= now_reg + 32'd1;
            if (is_arm && !full) cnt_reg <= cnt_reg + CW'(1);
            else if (shift_en) cnt_reg <= cnt_reg - CW'(1);
            if (ctl.accept)
            begin
                idx_reg <= cnt_reg;
                nres_reg <= '0;
                hold_v_reg <= 1'b0;
            end
            else
            begin
                if (idx_dec) idx_reg <= e_full;
                if (tick_hit)
                begin
                    nres_reg <= nres_reg + NRW'(1);
                    hold_v_reg <= 1'b1;
                end
            end
            if (push || emit_load) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_arm && !full)
        begin
            ids_reg[cnt_reg[IW-1:0]] <= req_id;
            start_reg[cnt_reg[IW-1:0]] <= now_reg;
            limit_reg[cnt_reg[IW-1:0]] <= wait_ms;
        end
        for (int j = 0; j < N - 1; j++)
        begin
            if (shift_en && (CW'(j) >= e_full))
            begin
                ids_reg[j] <= ids_reg[j + 1];
                start_reg[j] <= start_reg[j + 1];
                limit_reg[j] <= limit_reg[j + 1];
            end
        end
        if (tick_hit) hold_id_reg <= ids_reg[eidx];
        if (ctl.accept)
        begin
            res_id_reg <= '0;
            res_plen_reg <= '0;
            unique case (cmd)
                CMD_BYTE:
                begin
                    res_kind_reg <= KIND_FRAME;
                    res_id_reg <= new_fid;
                    res_plen_reg <= new_len - 8'd3;
                end
                CMD_TICK: res_kind_reg <= KIND_TIMEOUT;
                CMD_ARM:
                begin
                    res_kind_reg <= KIND_FULL;
                    res_id_reg <= req_id;
                end
                CMD_READ: res_kind_reg <= KIND_READ;
                default: res_kind_reg <= KIND_READ;
            endcase
        end
        if (push)
        begin
            kind_reg <= KIND_TIMEOUT;
            id_reg <= hold_id_reg;
            plen_reg <= '0;
            data_reg <= '0;
            last_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            kind_reg <= res_kind_reg;
            id_reg <= (res_kind_reg == KIND_TIMEOUT) ? hold_id_reg : res_id_reg;
            plen_reg <= res_plen_reg;
            if (res_kind_reg != KIND_READ) data_reg <= 8'd0;
            else if (rpos1_reg) data_reg <= len_reg;
            else data_reg <= rvld_reg ? rdata_reg : 8'd0;
            last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign frame_id = id_reg;
    assign payload_len = plen_reg;
    assign read_data = data_reg;
    assign last = last_reg;
endmodule
`default_nettype wire

>>> design/framed_receiver_with_reply_timeouts_core.sv
// Top level of the framed receiver with reply timeouts.
`default_nettype none
// One transaction is taken at a time. A received byte that does not end a frame
// and an arm that finds room do not stall the input. A read or a refused arm holds
// the input while its result is loaded into the result register, waiting while
// the result side stalls; the register presents it from the following cycle. A
// completed frame and a tick walk the pending table one entry per cycle from the
// newest entry down, a tick pausing while an expired entry waits on a stalled
// result side, and hold the input until the walk ends and the result is loaded;
// a tick that finds nothing expired loads no result. The pending table is read
// through a single port, one entry at a time. The frame store reads back as zero
// until a position is written, with no clearing pass.
module framed_receiver_with_reply_timeouts_core #(
    parameter int PENDING_ENTRIES = frs_pkg::PendingEntries
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  req_id,
    input  wire logic [31:0] wait_ms,
    input  wire logic [7:0]  read_pos,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       frame_id,
    output logic [7:0]       payload_len,
    output logic [7:0]       read_data,
    output logic             last
);
    import frs_pkg::*;

    ctrl_cmd_t ctl;
    dp_status_t st;

    frs_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .st(st),
        .ctl(ctl)
    );

    frs_dp #(
        .PENDING_ENTRIES(PENDING_ENTRIES)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .st(st),
        .cmd(cmd),
        .rx_byte(rx_byte),
        .req_id(req_id),
        .wait_ms(wait_ms),
        .read_pos(read_pos),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .kind(kind),
        .frame_id(frame_id),
        .payload_len(payload_len),
        .read_data(read_data),
        .last(last)
    );

    a_one_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.scan_rm && ctl.scan_tick))
        else $error("Removal and expiry scans are active together.");

    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit || ctl.scan_rm || ctl.scan_tick) |-> in_stall)
        else $error("A transaction was accepted while a result was in progress.");

    a_quiet_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan_tick && st.scan_end && !st.hold_valid) |=> !ctl.emit)
        else $error("A tick with no expiry produced a result.");
endmodule
`default_nettype wire
